@@ design/kspp_pkg.sv @@
// ----------------------------------------------------------------------------
// kspp_pkg: shared types and constants
// Widths, limits and the sequencer state type for the pair product search.
// ----------------------------------------------------------------------------
package kspp_pkg;

	localparam int VAL_W  = 31;
	localparam int PROD_W = 61;
	localparam int RANK_W = 19;

	localparam logic signed [VAL_W-1:0]  LIM_VAL     = 31'sd1000000000;
	localparam logic signed [VAL_W-1:0]  NEG_LIM_VAL = -31'sd1000000000;
	localparam logic signed [PROD_W-1:0] LIM_PROD    = 61'sd1000000000000000000;
	localparam logic signed [PROD_W-1:0] LOW_INIT    = -61'sd1000000000000000001;
	localparam logic signed [PROD_W-1:0] HIGH_INIT   = 61'sd1000000000000000001;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INS_RD,
		ST_INS_CMP,
		ST_INS_WR,
		ST_RND,
		ST_ELEM_RD,
		ST_ELEM_LD,
		ST_PROBE_RD,
		ST_PROBE_MUL,
		ST_PROBE_CMP,
		ST_ELEM_END,
		ST_RND_END,
		ST_OUT
	} state_t;

endpackage

@@ design/kspp_store.sv @@
// ----------------------------------------------------------------------------
// kspp_store: sorted element memory
// Single port synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module kspp_store import kspp_pkg::*; #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic                    clk,
	input  logic                    we,
	input  logic [AW-1:0]           addr,
	input  logic signed [VAL_W-1:0] wdata,
	output logic signed [VAL_W-1:0] rdata
);

	logic signed [VAL_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

@@ design/kth_smallest_pair_product_top.sv @@
// ----------------------------------------------------------------------------
// kth_smallest_pair_product_top: k-th smallest pair product
// Sorted load of elements, then a binary search on the product bound.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (value, last, in_valid/in_ready): one element per beat.
//   Each element is saturated to +-10^9 and, while the store has room,
//   inserted into a sorted RAM by shifting larger entries up one place,
//   one RAM access per cycle. A beat with last set starts the search: up
//   to 61 rounds, each running, for each of the n held elements, a binary
//   search of up to ceil(log2(n+1)) probes. A probe is a RAM read, multiply
//   and compare, an element adds a read, load and end step; one RAM port and
//   one multiplier keep them in order. Output channel (product, out_valid/
//   out_ready): one beat per last item. The result sits in an output
//   register; the block holds in ST_OUT while the receiver stalls and
//   accepts nothing new until it is taken. k_q is written via cfg_we/
//   cfg_wdata by the user only while idle; the block does not enforce it.
//   Reset sets k_q to 1, empties the store (count 0); RAM needs no clearing.
// ----------------------------------------------------------------------------
module kth_smallest_pair_product_top import kspp_pkg::*; #(
	parameter int MAX_N = 1024
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [VAL_W-1:0]  value,
	input  logic                     last,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [PROD_W-1:0] product,
	input  logic                     cfg_we,
	input  logic [RANK_W-1:0]        cfg_wdata
);

	localparam int AW = (MAX_N > 1) ? $clog2(MAX_N) : 1;
	localparam int CW = $clog2(MAX_N + 1);
	localparam int TW = 2 * CW + 1;

	state_t state_q, state_d;

	logic [RANK_W-1:0]        k_q;
	logic [CW-1:0]            cnt_q;
	logic [CW-1:0]            pos_q;
	logic signed [VAL_W-1:0]  v_q;
	logic                     last_q;
	logic signed [PROD_W-1:0] lo_q, hi_q, x_q;
	logic [TW-1:0]            tally_q;
	logic [CW-1:0]            i_q;
	logic signed [VAL_W-1:0]  a_q;
	logic signed [CW:0]       blo_q, bhi_q;
	logic signed [63:0]       prod_s2;
	logic signed [PROD_W-1:0] result_q;

	logic                     mem_we;
	logic [AW-1:0]            mem_addr;
	logic signed [VAL_W-1:0]  mem_wdata, mem_rdata;
	logic signed [VAL_W-1:0]  sat_v;
	logic signed [CW:0]       mid;
	logic signed [PROD_W:0]   bsum;
	logic                     below;
	logic signed [VAL_W-1:0]  mul_b;
	logic signed [2*VAL_W-1:0] pmul;

	kspp_store #(.DEPTH(MAX_N), .AW(AW)) u_store (
		.clk(clk), .we(mem_we), .addr(mem_addr), .wdata(mem_wdata), .rdata(mem_rdata)
	);

	always_comb begin
		if (value > LIM_VAL) sat_v = LIM_VAL;
		else if (value < NEG_LIM_VAL) sat_v = NEG_LIM_VAL;
		else sat_v = value;
	end

	assign mid = (blo_q + bhi_q) >>> 1;
	// Truncating toward zero as C does: add one before the shift when negative.
	assign bsum = {lo_q[PROD_W-1], lo_q} + {hi_q[PROD_W-1], hi_q};
	assign below = prod_s2 < 64'(x_q);

	// One shared multiplier: the square of the element at the end of its
	// search, the element times the probed entry otherwise.
	assign mul_b = (state_q == ST_ELEM_END) ? a_q : mem_rdata;
	assign pmul  = a_q * mul_b;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign product   = result_q;

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_addr  = pos_q[AW-1:0];
		mem_wdata = mem_rdata;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (cnt_q < CW'(MAX_N)) state_d = (cnt_q == '0) ? ST_INS_WR : ST_INS_RD;
					else state_d = last ? ST_RND : ST_IDLE;
				end
			end
			ST_INS_RD: begin
				// Read the entry below the hole (pos-1).
				mem_addr = AW'(pos_q - CW'(1));
				state_d  = ST_INS_CMP;
			end
			ST_INS_CMP: begin
				if (mem_rdata > v_q) begin
					mem_we    = 1'b1;
					mem_addr  = pos_q[AW-1:0];
					mem_wdata = mem_rdata;
					state_d   = (pos_q == CW'(1)) ? ST_INS_WR : ST_INS_RD;
				end else begin
					state_d = ST_INS_WR;
				end
			end
			ST_INS_WR: begin
				mem_we    = 1'b1;
				mem_wdata = v_q;
				state_d   = last_q ? ST_RND : ST_IDLE;
			end
			ST_RND: begin
				state_d = (lo_q + 61'sd1 < hi_q) ? ST_ELEM_RD : ST_OUT;
			end
			ST_ELEM_RD: begin
				mem_addr = i_q[AW-1:0];
				state_d  = (i_q == cnt_q) ? ST_RND_END : ST_ELEM_LD;
			end
			ST_ELEM_LD: state_d = ST_PROBE_RD;
			ST_PROBE_RD: begin
				mem_addr = AW'(mid);
				state_d  = (blo_q + 1 < bhi_q) ? ST_PROBE_MUL : ST_ELEM_END;
			end
			ST_PROBE_MUL: state_d = ST_PROBE_CMP;
			ST_PROBE_CMP: state_d = ST_PROBE_RD;
			ST_ELEM_END:  state_d = ST_ELEM_RD;
			ST_RND_END:   state_d = ST_RND;
			ST_OUT:       if (out_ready) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= RANK_W'(1);
			cnt_q   <= '0;
			lo_q    <= LOW_INIT;
			hi_q    <= HIGH_INIT;
			tally_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) k_q <= cfg_wdata;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						v_q    <= sat_v;
						last_q <= last;
						pos_q  <= cnt_q;
						i_q    <= '0;
					end
				end
				ST_INS_CMP: if (mem_rdata > v_q) pos_q <= pos_q - CW'(1);
				ST_INS_WR: begin
					cnt_q <= cnt_q + CW'(1);
					i_q   <= '0;
				end
				ST_RND: begin
					x_q     <= PROD_W'((bsum + {{PROD_W{1'b0}}, bsum[PROD_W]}) >>> 1);
					tally_q <= '0;
					i_q     <= '0;
					if (!(lo_q + 61'sd1 < hi_q)) begin
						result_q <= lo_q;
						cnt_q    <= '0;
						lo_q     <= LOW_INIT;
						hi_q     <= HIGH_INIT;
					end
				end
				ST_ELEM_LD: begin
					a_q   <= mem_rdata;
					blo_q <= '1;
					bhi_q <= (CW+1)'(cnt_q);
				end
				ST_PROBE_RD: pos_q <= CW'(mid);
				ST_PROBE_MUL: prod_s2 <= 64'(pmul);
				ST_PROBE_CMP: begin
					if ((a_q < 0) == below) bhi_q <= (CW+1)'(pos_q);
					else blo_q <= (CW+1)'(pos_q);
				end
				ST_ELEM_END: begin
					tally_q <= tally_q
						+ ((a_q < 0) ? TW'(cnt_q - CW'(bhi_q)) : TW'(bhi_q))
						- TW'(64'(pmul) < 64'(x_q));
					i_q <= i_q + CW'(1);
				end
				ST_RND_END: begin
					if (TW'(tally_q >> 1) < TW'(k_q)) lo_q <= x_q;
					else hi_q <= x_q;
				end
				default: ;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RND |-> lo_q < hi_q) else $error("bounds crossed");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_N)) else $error("count overflow");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(product)) else $error("result lost");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("accept during output");
`endif

endmodule
